@@ sv/mwm_pkg.sv @@
// Shared types and constants for the mecanum wheel mixer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mwm_pkg;

    localparam int CMD_W      = 16;            // command field width
    localparam int SUM_W      = CMD_W + 2;     // three-term wheel sum
    localparam int MAG_W      = CMD_W + 1;     // magnitude of a wheel sum
    localparam int LIM_W      = 15;            // speed limit register width
    localparam int PROD_W     = MAG_W + LIM_W; // magnitude times limit
    localparam int Q_W        = LIM_W;         // quotient never exceeds the limit
    localparam int WHEEL_W    = 16;            // result wheel width
    localparam int NUM_WHEELS = 4;
    localparam int FRONT_LAT  = 4;             // register stages in the mixing front end
    localparam int LANE_LAT   = Q_W + 2;       // product, one stage per quotient bit, sign

    localparam int ADDR_W     = 3;             // byte address of the APB port
    localparam int DATA_W     = 32;
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(10000);

    // Register index, taken from paddr[2]
    localparam logic REG_SPEED_LIMIT = 1'b0;

    typedef struct packed {
        logic signed [CMD_W-1:0] move_x;
        logic signed [CMD_W-1:0] move_y;
        logic signed [CMD_W-1:0] rotate;
    } cmd_t;

    typedef struct packed {
        logic signed [WHEEL_W-1:0] wheel_a;
        logic signed [WHEEL_W-1:0] wheel_b;
        logic signed [WHEEL_W-1:0] wheel_c;
        logic signed [WHEEL_W-1:0] wheel_d;
        logic                      was_scaled;
    } res_t;

    // Front end to divider lanes
    typedef struct packed {
        logic                             valid;
        logic                             scaled;
        logic [MAG_W-1:0]                 max;
        logic [NUM_WHEELS-1:0]            neg;
        logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    } mix_t;

endpackage

`default_nettype wire

@@ sv/mwm_front.sv @@
// Mixing front end: wheel sums, magnitudes, largest magnitude and scale flag.
// Depends on mwm_pkg.
`default_nettype none

module mwm_front
    import mwm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire cmd_t             cmd,
    input  wire logic [LIM_W-1:0] lim,
    output mix_t                  mix
);

    cmd_t                    cmd_reg;
    logic                    v1_reg;
    logic signed [SUM_W-1:0] sum_reg [NUM_WHEELS];
    logic signed [SUM_W-1:0] sum_next [NUM_WHEELS];
    logic                    v2_reg;
    logic [MAG_W-1:0]        mag_reg [NUM_WHEELS];
    logic [MAG_W-1:0]        mag_next [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   neg_reg;
    logic                    v3_reg;
    mix_t                    mix_reg;
    mix_t                    mix_next;
    logic [MAG_W-1:0]        max01;
    logic [MAG_W-1:0]        max23;

    // Stage 1: capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            cmd_reg <= cmd;
        end
    end

    // Stage 2: the four wheel sums
    always_comb
    begin
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] r;
        x = SUM_W'(cmd_reg.move_x);
        y = SUM_W'(cmd_reg.move_y);
        r = SUM_W'(cmd_reg.rotate);
        sum_next[0] = x - y + r;
        sum_next[1] = x + y + r;
        sum_next[2] = r - x + y;
        sum_next[3] = r - x - y;
    end

    // Stage 3: sign and magnitude
    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            mag_next[i] = sum_reg[i][SUM_W-1] ? MAG_W'(-sum_reg[i]) : MAG_W'(sum_reg[i]);
        end
    end

    // Stage 4: largest magnitude against the limit
    always_comb
    begin
        max01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        max23 = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
        mix_next.valid  = v3_reg;
        mix_next.max    = (max01 > max23) ? max01 : max23;
        mix_next.scaled = mix_next.max > MAG_W'(lim);
        mix_next.neg    = neg_reg;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            mix_next.mag[i] = mag_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            mix_reg <= '0;
        end
        else
        begin
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            mix_reg <= mix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            sum_reg[i] <= sum_next[i];
            mag_reg[i] <= mag_next[i];
            neg_reg[i] <= sum_reg[i][SUM_W-1];
        end
    end

    assign mix = mix_reg;

endmodule

`default_nettype wire

@@ sv/mwm_lane.sv @@
// One wheel lane: magnitude times limit, pipelined restoring division by the
// largest magnitude (one quotient bit per stage), then sign restore. Uses mwm_pkg.
`default_nettype none

module mwm_lane
    import mwm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic [MAG_W-1:0]          mag,
    input  wire logic                      neg,
    input  wire logic [MAG_W-1:0]          max,
    input  wire logic                      scaled,
    input  wire logic [LIM_W-1:0]          lim,
    output logic signed [WHEEL_W-1:0]      wheel
);

    logic [PROD_W-1:0]  rem_reg  [Q_W+1];
    logic [MAG_W-1:0]   div_reg  [Q_W+1];
    logic [Q_W-1:0]     quo_reg  [Q_W+1];
    logic [Q_W-1:0]     pass_reg [Q_W+1];
    logic [Q_W:0]       neg_reg;
    logic [Q_W:0]       scl_reg;
    logic [Q_W-1:0]     val;
    logic [WHEEL_W-1:0] wheel_next;
    logic [WHEEL_W-1:0] wheel_reg;

    // Product stage
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= PROD_W'(mag) * PROD_W'(lim);
        div_reg[0]  <= max;
        quo_reg[0]  <= '0;
        pass_reg[0] <= mag[Q_W-1:0];
        neg_reg[0]  <= neg;
        scl_reg[0]  <= scaled;
    end

    // Division stages, most significant quotient bit first
    for (genvar j = 1; j <= Q_W; j++)
    begin : g_div
        localparam int SH = Q_W - j;
        logic [PROD_W-1:0] dsh;
        logic              take;
        logic [PROD_W-1:0] rem_next;

        always_comb
        begin
            dsh      = PROD_W'(div_reg[j-1]) << SH;
            take     = rem_reg[j-1] >= dsh;
            rem_next = take ? (rem_reg[j-1] - dsh) : rem_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next;
            div_reg[j]  <= div_reg[j-1];
            quo_reg[j]  <= {quo_reg[j-1][Q_W-2:0], take};
            pass_reg[j] <= pass_reg[j-1];
            neg_reg[j]  <= neg_reg[j-1];
            scl_reg[j]  <= scl_reg[j-1];
        end
    end

    // Select scaled or unchanged magnitude, restore sign
    always_comb
    begin
        val        = scl_reg[Q_W] ? quo_reg[Q_W] : pass_reg[Q_W];
        wheel_next = neg_reg[Q_W] ? WHEEL_W'(-{1'b0, val}) : WHEEL_W'({1'b0, val});
    end

    always_ff @(posedge clk)
    begin
        wheel_reg <= wheel_next;
    end

    assign wheel = wheel_reg;

endmodule

`default_nettype wire

@@ sv/mecanum_wheel_mixer.sv @@
// Mecanum wheel mixer: an accepted request passes the front end and lane stages
// and shows its result with done high; throughput one request per cycle. Front
// end and divider lanes set the depth, a lane stage per quotient bit. busy is
// always low; results cannot be held off. Reset clears all valid bits at once
// and loads speed_limit with 10000. Uses mwm_pkg, mwm_front, mwm_lane.
`default_nettype none

module mecanum_wheel_mixer
    import mwm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Request channel
    input  wire logic              start,
    output logic                   busy,
    input  wire cmd_t              cmd,
    // Result channel
    output logic                   done,
    output res_t                   result,
    // APB configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int PIPE_LAT = FRONT_LAT + LANE_LAT;

    logic [LIM_W-1:0]          limit_reg;
    logic [LIM_W-1:0]          limit_next;
    logic                      accept;
    mix_t                      mix;
    logic signed [WHEEL_W-1:0] wheel [NUM_WHEELS];
    logic [LANE_LAT-1:0]       vld_reg;
    logic [LANE_LAT-1:0]       vld_next;
    logic [LANE_LAT-1:0]       scl_reg;
    logic [WHEEL_W-1:0]        wmag [NUM_WHEELS];

    // ------------------------------------------------------------------
    // Configuration: one register at paddr[2] == 0, word-aligned. Writes
    // land on the access cycle; reads return the limit zero-extended.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_SPEED_LIMIT))
        begin
            limit_next = pwdata[LIM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata = (paddr[2] == REG_SPEED_LIMIT) ? DATA_W'(limit_reg) : '0;

    // ------------------------------------------------------------------
    // Request side: the pipeline never stalls, so take a request every cycle.
    // ------------------------------------------------------------------
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Sums, magnitudes, largest magnitude and scale decision
    mwm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_valid(accept),
        .cmd    (cmd),
        .lim    (limit_reg),
        .mix    (mix)
    );

    // One multiply-divide lane per wheel
    for (genvar i = 0; i < NUM_WHEELS; i++)
    begin : g_lane
        mwm_lane u_lane (
            .clk   (clk),
            .mag   (mix.mag[i]),
            .neg   (mix.neg[i]),
            .max   (mix.max),
            .scaled(mix.scaled),
            .lim   (limit_reg),
            .wheel (wheel[i])
        );
    end

    // ------------------------------------------------------------------
    // Valid and scale flag travel beside the lanes, same depth.
    // ------------------------------------------------------------------
    assign vld_next = {vld_reg[LANE_LAT-2:0], mix.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scl_reg <= {scl_reg[LANE_LAT-2:0], mix.scaled};
    end

    // Result: drive the strobe for the single cycle the lanes hold the request
    assign done              = vld_reg[LANE_LAT-1];
    assign result.wheel_a    = wheel[0];
    assign result.wheel_b    = wheel[1];
    assign result.wheel_c    = wheel[2];
    assign result.wheel_d    = wheel[3];
    assign result.was_scaled = scl_reg[LANE_LAT-1];

    // Wheel magnitudes, for checking the limit on the way out
    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            wmag[i] = wheel[i][WHEEL_W-1] ? WHEEL_W'(-wheel[i]) : WHEEL_W'(wheel[i]);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LAT done)
        else $error("request did not reach the result port on time");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LAT))
        else $error("result strobe without a matching request");

    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wmag[0] <= WHEEL_W'(limit_reg)) && (wmag[1] <= WHEEL_W'(limit_reg))
              && (wmag[2] <= WHEEL_W'(limit_reg)) && (wmag[3] <= WHEEL_W'(limit_reg)))
        else $error("wheel speed above the speed limit");

endmodule

`default_nettype wire
